// ===== design/scint_pkg.sv =====
// Shared constants and types for the segment/circle intersection pipeline.
package scint_pkg;

  // Default coordinate width: signed Q12.4.
  localparam int COORD_BITS_DEF = 16;

  // Register stages from input acceptance to the output register.
  localparam int SCINT_DEPTH = 7;

  // Outcome of the quadratic at the segment endpoints.
  typedef struct packed {
    logic a_zero;   // zero-length segment
    logic c0_zero;  // start point on the circle
    logic c1_zero;  // end point on the circle
    logic c0_neg;   // start point inside
    logic c1_neg;   // end point inside
  } scint_flags_t;

  // Decision carried alongside the discriminant products.
  typedef struct packed {
    logic decided;  // answer known without the discriminant
    logic hit;      // answer when decided
  } scint_dec_t;

endpackage

// ===== design/segment_circle_intersect.sv =====
// Top level: segment/circle intersection test, seven-stage pipeline.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    segment endpoints, circle center, radius
//   out_     output     out_valid/out_ready  out_hit
//
// One item per cycle sustained while out_ready is high.
// The depth is set by the discriminant path: coefficient multiplies, a
// coefficient sum, then h^2 and a*c0 as split partial products and their sum.
// Reset (synchronous, rst_n low) empties every stage; payload is not cleared.
// A stall on out_ready holds the output; earlier stages keep filling empty
// slots, so in_ready drops only when all seven stages hold items.
module segment_circle_intersect #(
  parameter int COORD_BITS = scint_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_seg_start_x,
  input  logic signed [COORD_BITS-1:0] in_seg_start_y,
  input  logic signed [COORD_BITS-1:0] in_seg_end_x,
  input  logic signed [COORD_BITS-1:0] in_seg_end_y,
  input  logic signed [COORD_BITS-1:0] in_center_x,
  input  logic signed [COORD_BITS-1:0] in_center_y,
  input  logic        [COORD_BITS-2:0] in_radius,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_hit
);
  import scint_pkg::*;

  localparam int SW = 2 * COORD_BITS + 4;
  localparam int QW = 4 * COORD_BITS + 4;

  logic                 g_valid, g_ready;
  logic signed [SW-1:0] g_a, g_c0, g_h;
  scint_flags_t         g_flags;

  logic                 d_valid, d_ready;
  logic [QW-1:0]        d_hsq, d_ac;
  scint_dec_t           d_dec;

  logic out_valid_r, out_hit_r;
  logic en_out;

  scint_geom #(.COORD_BITS(COORD_BITS)) u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_valid),
    .up_ready  (in_ready),
    .x1        (in_seg_start_x),
    .y1        (in_seg_start_y),
    .x2        (in_seg_end_x),
    .y2        (in_seg_end_y),
    .cx        (in_center_x),
    .cy        (in_center_y),
    .r         (in_radius),
    .dn_valid  (g_valid),
    .dn_ready  (g_ready),
    .a_out     (g_a),
    .c0_out    (g_c0),
    .h_out     (g_h),
    .flags_out (g_flags)
  );

  scint_disc #(.COORD_BITS(COORD_BITS)) u_disc (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (g_valid),
    .up_ready (g_ready),
    .a_in     (g_a),
    .c0_in    (g_c0),
    .h_in     (g_h),
    .flags_in (g_flags),
    .dn_valid (d_valid),
    .dn_ready (d_ready),
    .hsq_out  (d_hsq),
    .ac_out   (d_ac),
    .dec_out  (d_dec)
  );

  // output register: discriminant h^2 - a*c0 >= 0 when not yet decided
  assign en_out  = !out_valid_r || out_ready;
  assign d_ready = en_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_hit_r <= d_dec.decided ? d_dec.hit : (d_hsq >= d_ac);
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

endmodule

// ===== design/scint_geom.sv =====
// Stages 1-3: coordinate differences, products, quadratic coefficients.
module scint_geom #(
  parameter int COORD_BITS = scint_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic signed [COORD_BITS-1:0] x1,
  input  logic signed [COORD_BITS-1:0] y1,
  input  logic signed [COORD_BITS-1:0] x2,
  input  logic signed [COORD_BITS-1:0] y2,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  input  logic        [COORD_BITS-2:0] r,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output logic signed [2*COORD_BITS+3:0] a_out,
  output logic signed [2*COORD_BITS+3:0] c0_out,
  output logic signed [2*COORD_BITS+3:0] h_out,
  output scint_pkg::scint_flags_t      flags_out
);
  import scint_pkg::*;

  localparam int DW = COORD_BITS + 1;      // difference width
  localparam int PW = 2 * DW;              // signed product width
  localparam int RW = 2 * COORD_BITS - 2;  // radius square width
  localparam int SW = 2 * COORD_BITS + 4;  // coefficient width

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  // stage 1 registers
  logic signed [DW-1:0] dx_r, dy_r, fx_r, fy_r, ex_r, ey_r;
  logic [COORD_BITS-2:0] r_r;
  // stage 2 registers
  logic signed [PW-1:0] dxx_r, dyy_r, fxx_r, fyy_r, exx_r, eyy_r, fdx_r, fdy_r;
  logic [RW-1:0] rr_r;
  // stage 3 registers
  logic signed [SW-1:0] a_r, c0_r, h_r;
  scint_flags_t flags_r;

  logic signed [SW-1:0] a_nxt, c0_nxt, c1_nxt, h_nxt;

  // stall chain: a stage loads when empty or when its successor moves
  assign en3      = !v3_r || dn_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= up_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // stage 1: d = end - start, f = start - center, e = end - center
  always_ff @(posedge clk) begin
    if (en1) begin
      dx_r <= DW'(x2) - DW'(x1);
      dy_r <= DW'(y2) - DW'(y1);
      fx_r <= DW'(x1) - DW'(cx);
      fy_r <= DW'(y1) - DW'(cy);
      ex_r <= DW'(x2) - DW'(cx);
      ey_r <= DW'(y2) - DW'(cy);
      r_r  <= r;
    end
  end

  // stage 2: one multiply per term
  always_ff @(posedge clk) begin
    if (en2) begin
      dxx_r <= dx_r * dx_r;
      dyy_r <= dy_r * dy_r;
      fxx_r <= fx_r * fx_r;
      fyy_r <= fy_r * fy_r;
      exx_r <= ex_r * ex_r;
      eyy_r <= ey_r * ey_r;
      fdx_r <= fx_r * dx_r;
      fdy_r <= fy_r * dy_r;
      rr_r  <= RW'(r_r) * RW'(r_r);
    end
  end

  // stage 3: a = |d|^2, c0/c1 = quadratic at t=0/1, h = f.d
  always_comb begin
    a_nxt  = SW'(dxx_r) + SW'(dyy_r);
    c0_nxt = SW'(fxx_r) + SW'(fyy_r) - $signed({{(SW-RW){1'b0}}, rr_r});
    c1_nxt = SW'(exx_r) + SW'(eyy_r) - $signed({{(SW-RW){1'b0}}, rr_r});
    h_nxt  = SW'(fdx_r) + SW'(fdy_r);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      a_r             <= a_nxt;
      c0_r            <= c0_nxt;
      h_r             <= h_nxt;
      flags_r.a_zero  <= (a_nxt == '0);
      flags_r.c0_zero <= (c0_nxt == '0);
      flags_r.c1_zero <= (c1_nxt == '0);
      flags_r.c0_neg  <= c0_nxt[SW-1];
      flags_r.c1_neg  <= c1_nxt[SW-1];
    end
  end

  assign dn_valid  = v3_r;
  assign a_out     = a_r;
  assign c0_out    = c0_r;
  assign h_out     = h_r;
  assign flags_out = flags_r;

endmodule

// ===== design/scint_wmul.sv =====
// Two-stage unsigned multiplier split into four half-width partial products.
module scint_wmul #(
  parameter int MW = 34
) (
  input  logic            clk,
  input  logic            en_pp,
  input  logic            en_sum,
  input  logic [MW-1:0]   op_a,
  input  logic [MW-1:0]   op_b,
  output logic [2*MW-1:0] prod
);
  localparam int HW = MW / 2;
  localparam int LW = MW - HW;   // low half width
  localparam int PW = 2 * MW;

  logic [2*HW-1:0]    hh_r;
  logic [HW+LW-1:0]   hl_r, lh_r;
  logic [2*LW-1:0]    ll_r;
  logic [PW-1:0]      prod_r;

  // partial products, each at most half by half width
  always_ff @(posedge clk) begin
    if (en_pp) begin
      hh_r <= (2*HW)'(op_a[MW-1:LW]) * (2*HW)'(op_b[MW-1:LW]);
      hl_r <= (HW+LW)'(op_a[MW-1:LW]) * (HW+LW)'(op_b[LW-1:0]);
      lh_r <= (HW+LW)'(op_a[LW-1:0]) * (HW+LW)'(op_b[MW-1:LW]);
      ll_r <= (2*LW)'(op_a[LW-1:0]) * (2*LW)'(op_b[LW-1:0]);
    end
  end

  // recombine at their weights
  always_ff @(posedge clk) begin
    if (en_sum) begin
      prod_r <= (PW'(hh_r) << (2*LW)) + ((PW'(hl_r) + PW'(lh_r)) << LW) + PW'(ll_r);
    end
  end

  assign prod = prod_r;

endmodule

// ===== design/scint_disc.sv =====
// Stages 4-6: endpoint/vertex decision and discriminant products.
module scint_disc #(
  parameter int COORD_BITS = scint_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic signed [2*COORD_BITS+3:0] a_in,
  input  logic signed [2*COORD_BITS+3:0] c0_in,
  input  logic signed [2*COORD_BITS+3:0] h_in,
  input  scint_pkg::scint_flags_t       flags_in,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic [4*COORD_BITS+3:0]       hsq_out,
  output logic [4*COORD_BITS+3:0]       ac_out,
  output scint_pkg::scint_dec_t         dec_out
);
  import scint_pkg::*;

  localparam int SW = 2 * COORD_BITS + 4;  // signed coefficient width
  localparam int MW = 2 * COORD_BITS + 2;  // magnitude width

  logic v4_r, v5_r, v6_r;
  logic en4, en5, en6;

  logic [MW-1:0] hmag_r, amag_r, c0mag_r;
  scint_dec_t dec4_r, dec5_r, dec6_r;
  scint_dec_t dec_nxt;

  logic signed [SW-1:0] ah;
  logic signed [SW-1:0] hneg;
  logic                 h_pos;

  assign en6      = !v6_r || dn_ready;
  assign en5      = !v5_r || en6;
  assign en4      = !v4_r || en5;
  assign up_ready = en4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en4) v4_r <= up_valid;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
    end
  end

  // stage 4: settle every case that needs no discriminant
  always_comb begin
    ah    = a_in + h_in;
    hneg  = -h_in;
    h_pos = !h_in[SW-1] && (h_in != '0);
    dec_nxt = '{decided: 1'b1, hit: 1'b0};
    if (flags_in.a_zero) begin
      dec_nxt.hit = 1'b0;
    end else if (flags_in.c0_zero || flags_in.c1_zero) begin
      dec_nxt.hit = 1'b1;
    end else if (flags_in.c0_neg != flags_in.c1_neg) begin
      dec_nxt.hit = 1'b1;
    end else if (flags_in.c0_neg) begin
      // both endpoints inside
      dec_nxt.hit = 1'b0;
    end else if (h_pos || ah[SW-1]) begin
      // closest point of the line falls outside the segment
      dec_nxt.hit = 1'b0;
    end else begin
      dec_nxt.decided = 1'b0;
    end
  end

  // magnitudes are only used when h <= 0 and c0 > 0
  always_ff @(posedge clk) begin
    if (en4) begin
      hmag_r  <= MW'(hneg);
      amag_r  <= MW'(a_in);
      c0mag_r <= MW'(c0_in);
      dec4_r  <= dec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) dec5_r <= dec4_r;
    if (en6) dec6_r <= dec5_r;
  end

  // stages 5-6: h^2 and a*c0
  scint_wmul #(.MW(MW)) u_hsq (
    .clk    (clk),
    .en_pp  (en5),
    .en_sum (en6),
    .op_a   (hmag_r),
    .op_b   (hmag_r),
    .prod   (hsq_out)
  );

  scint_wmul #(.MW(MW)) u_ac (
    .clk    (clk),
    .en_pp  (en5),
    .en_sum (en6),
    .op_a   (amag_r),
    .op_b   (c0mag_r),
    .prod   (ac_out)
  );

  assign dn_valid = v6_r;
  assign dec_out  = dec6_r;

endmodule

// ===== design/scint_chk.sv =====
// Port-level checks for the intersection pipeline, bound to the top level.
module scint_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_hit
);
  import scint_pkg::*;

  localparam int CW = $clog2(SCINT_DEPTH + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // items in flight
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && !out_acc) cnt_nxt = cnt_r + CW'(1);
    if (!in_acc && out_acc) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit))
    else $error("stalled result changed");

  // no result without an item in flight
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("result with no item in flight");

  // a full, stalled pipeline refuses input
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == CW'(SCINT_DEPTH)) && !out_ready |-> !in_ready)
    else $error("input taken while pipeline full");

endmodule

bind segment_circle_intersect scint_chk u_scint_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_hit   (out_hit)
);
